@@ rtl/wrs_pkg.sv @@
// Shared constants, codes and types for the weighted rendezvous selector.
package wrs_pkg;

    localparam int WRS_PEERS = 16;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_SELECT = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;
    localparam logic [1:0] FUNC_SPARE  = 2'd3;

    localparam logic [1:0] OUTC_SUCCESS = 2'd0;
    localparam logic [1:0] OUTC_FAILURE = 2'd1;
    localparam logic [1:0] OUTC_NEUTRAL = 2'd2;
    localparam logic [1:0] OUTC_SPARE   = 2'd3;

    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_SELECTED = 2'd1;
    localparam logic [1:0] STAT_NONE     = 2'd2;

    localparam logic [3:0] CFG_FAIL_LIMIT    = 4'd0;
    localparam logic [3:0] CFG_RETRY_TIMEOUT = 4'd1;

    localparam logic [7:0]  FAIL_LIMIT_RST    = 8'd1;
    localparam logic [31:0] RETRY_TIMEOUT_RST = 32'd10000;

    localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2   = 64'h94d049bb133111eb;
    localparam logic [31:0] LN2_Q32    = 32'hB17217F8;
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

    typedef struct packed {
        logic [63:0] node_hash;
        logic [15:0] weight;
        logic [7:0]  fail_count;
        logic [47:0] last_checked;
        logic [47:0] last_failed;
    } wrs_entry_t;

    // Odd-reciprocal series coefficients, floor(2^32 / (2k+1)).
    function automatic logic [32:0] wrs_coef(input logic [3:0] k);
        logic [32:0] c;
        case (k)
            4'd0:    c = 33'h1_0000_0000;
            4'd1:    c = 33'h0_5555_5555;
            4'd2:    c = 33'h0_3333_3333;
            4'd3:    c = 33'h0_2492_4924;
            4'd4:    c = 33'h0_1C71_C71C;
            4'd5:    c = 33'h0_1745_D174;
            4'd6:    c = 33'h0_13B1_3B13;
            4'd7:    c = 33'h0_1111_1111;
            4'd8:    c = 33'h0_0F0F_0F0F;
            4'd9:    c = 33'h0_0D79_435E;
            4'd10:   c = 33'h0_0C30_C30C;
            4'd11:   c = 33'h0_0B21_642C;
            4'd12:   c = 33'h0_0A3D_70A3;
            4'd13:   c = 33'h0_097B_425E;
            4'd14:   c = 33'h0_08D3_DCB0;
            default: c = 33'h0_0842_1084;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/weighted_rendezvous_selector_core.sv @@
// Weighted rendezvous peer selector with per-peer circuit breaker.
//
// The peer table lives in one synchronous memory with valid bits that reset clears at once, so
// there is no clearing pass. One transaction is worked on at a time. In a select each usable
// peer goes through one shared 33x33 multiplier (splitmix mixing as 32-bit partial products,
// the log-series Horner steps and the cost cross-multiply), a six-step leading-zero
// normalizer and a radix-2 divider of 32 steps.
module weighted_rendezvous_selector_core
    import wrs_pkg::*;
#(
    parameter int PEERS = WRS_PEERS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Request channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [3:0]  s_entry,
    input  logic [63:0] s_peer_hash,
    input  logic [15:0] s_weight,
    input  logic [63:0] s_key,
    input  logic [15:0] s_exclude_mask,
    input  logic [47:0] s_now,
    input  logic [1:0]  s_outcome,
    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_chosen
);

    localparam int IDX_W = $clog2(PEERS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DONE, ST_RPT,
        ST_SRD, ST_SCHK, ST_MIX0, ST_M0, ST_M1, ST_M2, ST_M3,
        ST_NORM, ST_DIVI, ST_DIV, ST_Z2, ST_Z2W, ST_H, ST_HW, ST_T, ST_TW,
        ST_C1, ST_C2, ST_C3, ST_SEND, ST_SUPD
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [7:0]  fail_limit_reg;
    logic [31:0] retry_timeout_reg;

    // Latched request.
    logic [1:0]  outcome_reg;
    logic        in_range_reg;
    logic [IDX_W-1:0] entry_reg;
    logic [63:0] key_reg;
    logic [15:0] mask_reg;
    logic [47:0] now_reg;

    // Result register.
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [3:0]  m_chosen_reg;
    logic [1:0]  res_status_reg;
    logic [3:0]  res_chosen_reg;

    // Peer table memory with one valid bit per entry.
    wrs_entry_t peer_mem [PEERS];
    logic [PEERS-1:0] vld_reg;
    wrs_entry_t rd_data_reg;
    logic       rd_vld_reg;
    wrs_entry_t ent;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    wrs_entry_t       mem_wd;

    // Select datapath.
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] best_reg;
    logic             found_reg;
    logic [31:0]      best_l_reg;
    logic [15:0]      best_w_reg;
    logic [15:0]      cur_w_reg;
    logic [63:0]      hash_reg;
    logic [63:0]      v_reg;
    logic [63:0]      acc_reg;
    logic             mix_pass_reg;
    logic [63:0]      x_reg;
    logic [5:0]       e_reg;
    logic [2:0]       nstep_reg;
    logic [32:0]      rem_reg;
    logic [32:0]      den_reg;
    logic [31:0]      q_reg;
    logic [4:0]       qcnt_reg;
    logic [38:0]      eln_reg;
    logic [31:0]      z2_reg;
    logic [32:0]      p_reg;
    logic [3:0]       k_reg;
    logic [31:0]      l_reg;
    logic [47:0]      lhs_reg;

    // Shared multiplier with a registered product.
    logic [32:0] mul_a;
    logic [32:0] mul_b;
    logic [65:0] prod_reg;

    logic        in_range;
    logic        usable;
    logic        hi_zero;
    logic [5:0]  nshift;
    logic [63:0] mix_c;
    logic [63:0] mix_sum;
    logic [63:0] mix_in;
    logic [63:0] mix_out;
    logic [33:0] div_r2;
    logic [38:0] cost_sum;
    logic        last_entry;

    function automatic logic [47:0] elapsed_f(input logic [47:0] now, input logic [47:0] lc);
        return (now >= lc) ? (now - lc) : 48'd0;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_chosen  = m_chosen_reg;

    assign in_range   = (32'(s_entry) < 32'(PEERS));
    assign ent        = rd_vld_reg ? rd_data_reg : '0;
    assign last_entry = (cnt_reg == IDX_W'(PEERS - 1));
    assign mix_c      = mix_pass_reg ? MIX_MUL2 : MIX_MUL1;
    assign mix_in     = key_reg ^ (hash_reg + MIX_GOLDEN);
    assign mix_sum    = acc_reg + {prod_reg[31:0], 32'd0};
    assign mix_out    = mix_sum ^ (mix_sum >> 31);
    assign div_r2     = {rem_reg, 1'b0};
    assign cost_sum   = eln_reg + 39'(prod_reg[65:31]);
    assign nshift     = 6'd32 >> nstep_reg;

    // A peer is usable when it holds a weight, is not masked off and its breaker admits it.
    assign usable = (ent.weight != 16'd0)
        && !((32'(cnt_reg) < 32'd16) && mask_reg[4'(cnt_reg)])
        && ((fail_limit_reg == 8'd0) || (ent.fail_count < fail_limit_reg)
            || (elapsed_f(now_reg, ent.last_checked) > {16'd0, retry_timeout_reg}));

    always_comb begin
        case (nstep_reg)
            3'd0:    hi_zero = (x_reg[63:32] == 32'd0);
            3'd1:    hi_zero = (x_reg[63:48] == 16'd0);
            3'd2:    hi_zero = (x_reg[63:56] == 8'd0);
            3'd3:    hi_zero = (x_reg[63:60] == 4'd0);
            3'd4:    hi_zero = (x_reg[63:62] == 2'd0);
            default: hi_zero = !x_reg[63];
        endcase
    end

    // Memory address, write-back and multiplier operand selection.
    always_comb begin
        rd_addr = cnt_reg;
        mem_we  = 1'b0;
        mem_wa  = cnt_reg;
        mem_wd  = ent;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            ST_IDLE: begin
                rd_addr = IDX_W'(s_entry);
                mem_wa  = IDX_W'(s_entry);
                if (s_valid && (s_func == FUNC_LOAD) && in_range) begin
                    mem_we = 1'b1;
                    mem_wd = '0;
                    mem_wd.node_hash = s_peer_hash;
                    mem_wd.weight    = s_weight;
                end
            end
            ST_RPT: begin
                rd_addr = entry_reg;
                mem_wa  = entry_reg;
                if (in_range_reg && (ent.weight != 16'd0)) begin
                    if (outcome_reg == OUTC_SUCCESS) begin
                        if (ent.last_failed < ent.last_checked) begin
                            mem_we = 1'b1;
                            mem_wd.fail_count = 8'd0;
                        end
                    end else if (outcome_reg == OUTC_FAILURE) begin
                        mem_we = 1'b1;
                        if (ent.fail_count != 8'hFF) begin
                            mem_wd.fail_count = ent.fail_count + 8'd1;
                        end
                        if (now_reg > ent.last_checked) begin
                            mem_wd.last_checked = now_reg;
                            mem_wd.last_failed  = now_reg;
                        end else begin
                            mem_wd.last_failed  = ent.last_checked;
                        end
                    end
                end
            end
            ST_SEND: rd_addr = best_reg;
            ST_SUPD: begin
                rd_addr = best_reg;
                mem_wa  = best_reg;
                if (elapsed_f(now_reg, ent.last_checked) > {16'd0, retry_timeout_reg}) begin
                    mem_we = 1'b1;
                    mem_wd.last_checked = now_reg;
                end
            end
            ST_M0: begin
                mul_a = {1'b0, v_reg[31:0]};
                mul_b = {1'b0, mix_c[31:0]};
            end
            ST_M1: begin
                mul_a = {1'b0, v_reg[63:32]};
                mul_b = {1'b0, mix_c[31:0]};
            end
            ST_M2: begin
                mul_a = {1'b0, v_reg[31:0]};
                mul_b = {1'b0, mix_c[63:32]};
            end
            ST_Z2: begin
                mul_a = {1'b0, q_reg};
                mul_b = {1'b0, q_reg};
            end
            ST_H: begin
                mul_a = {1'b0, z2_reg};
                mul_b = p_reg;
            end
            ST_T: begin
                mul_a = {1'b0, q_reg};
                mul_b = p_reg;
            end
            ST_C1: begin
                mul_a = {1'b0, l_reg};
                mul_b = {17'd0, best_w_reg};
            end
            ST_C2: begin
                mul_a = {1'b0, best_l_reg};
                mul_b = {17'd0, cur_w_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Peer table: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            peer_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= peer_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_reg[mem_wa] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_limit_reg    <= FAIL_LIMIT_RST;
            retry_timeout_reg <= RETRY_TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FAIL_LIMIT:    fail_limit_reg    <= cfg_data[7:0];
                CFG_RETRY_TIMEOUT: retry_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        outcome_reg    <= s_outcome;
                        in_range_reg   <= in_range;
                        entry_reg      <= IDX_W'(s_entry);
                        key_reg        <= s_key;
                        mask_reg       <= s_exclude_mask;
                        now_reg        <= s_now;
                        res_status_reg <= STAT_DONE;
                        res_chosen_reg <= 4'd0;
                        cnt_reg        <= '0;
                        found_reg      <= 1'b0;
                        case (s_func)
                            FUNC_SELECT: state_reg <= ST_SRD;
                            FUNC_REPORT: state_reg <= ST_RPT;
                            default:     state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_RPT: state_reg <= ST_DONE;
                ST_SRD: state_reg <= ST_SCHK;
                ST_SCHK: begin
                    hash_reg  <= ent.node_hash;
                    cur_w_reg <= ent.weight;
                    if (usable) begin
                        state_reg <= ST_MIX0;
                    end else if (last_entry) begin
                        state_reg      <= found_reg ? ST_SEND : ST_DONE;
                        res_status_reg <= STAT_NONE;
                    end else begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_SRD;
                    end
                end
                ST_MIX0: begin
                    v_reg        <= mix_in ^ (mix_in >> 30);
                    mix_pass_reg <= 1'b0;
                    state_reg    <= ST_M0;
                end
                ST_M0: state_reg <= ST_M1;
                ST_M1: begin
                    acc_reg   <= prod_reg[63:0];
                    state_reg <= ST_M2;
                end
                ST_M2: begin
                    acc_reg   <= mix_sum;
                    state_reg <= ST_M3;
                end
                ST_M3: begin
                    if (mix_pass_reg) begin
                        // Mixed hash is ready: line up the 54-bit odd mantissa at bit 63.
                        x_reg     <= {mix_out[63:11], 1'b1, 10'd0};
                        e_reg     <= 6'd0;
                        nstep_reg <= 3'd0;
                        state_reg <= ST_NORM;
                    end else begin
                        v_reg        <= mix_sum ^ (mix_sum >> 27);
                        mix_pass_reg <= 1'b1;
                        state_reg    <= ST_M0;
                    end
                end
                ST_NORM: begin
                    if (hi_zero) begin
                        x_reg <= x_reg << nshift;
                        e_reg <= e_reg + nshift;
                    end
                    nstep_reg <= nstep_reg + 3'd1;
                    if (nstep_reg == 3'd5) begin
                        state_reg <= ST_DIVI;
                    end
                end
                ST_DIVI: begin
                    rem_reg   <= ONE_Q32 - {1'b0, x_reg[63:32]};
                    den_reg   <= ONE_Q32 + {1'b0, x_reg[63:32]};
                    q_reg     <= 32'd0;
                    qcnt_reg  <= 5'd0;
                    eln_reg   <= 39'(e_reg) * 39'(LN2_Q32) + 39'd32;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_r2 >= {1'b0, den_reg}) begin
                        rem_reg <= 33'(div_r2 - {1'b0, den_reg});
                        q_reg   <= {q_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= div_r2[32:0];
                        q_reg   <= {q_reg[30:0], 1'b0};
                    end
                    qcnt_reg <= qcnt_reg + 5'd1;
                    if (qcnt_reg == 5'd31) begin
                        state_reg <= ST_Z2;
                    end
                end
                ST_Z2: state_reg <= ST_Z2W;
                ST_Z2W: begin
                    z2_reg    <= prod_reg[63:32];
                    p_reg     <= wrs_coef(4'd15);
                    k_reg     <= 4'd14;
                    state_reg <= ST_H;
                end
                ST_H: state_reg <= ST_HW;
                ST_HW: begin
                    p_reg <= 33'({1'b0, wrs_coef(k_reg)} + prod_reg[65:32]);
                    if (k_reg == 4'd0) begin
                        state_reg <= ST_T;
                    end else begin
                        k_reg     <= k_reg - 4'd1;
                        state_reg <= ST_H;
                    end
                end
                ST_T: state_reg <= ST_TW;
                ST_TW: begin
                    l_reg     <= cost_sum[37:6];
                    state_reg <= ST_C1;
                end
                ST_C1: state_reg <= ST_C2;
                ST_C2: begin
                    lhs_reg   <= prod_reg[47:0];
                    state_reg <= ST_C3;
                end
                ST_C3: begin
                    if (!found_reg || (lhs_reg < prod_reg[47:0])) begin
                        found_reg  <= 1'b1;
                        best_reg   <= cnt_reg;
                        best_l_reg <= l_reg;
                        best_w_reg <= cur_w_reg;
                    end
                    if (last_entry) begin
                        state_reg <= ST_SEND;
                    end else begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_SRD;
                    end
                end
                ST_SEND: state_reg <= ST_SUPD;
                ST_SUPD: begin
                    res_status_reg <= STAT_SELECTED;
                    res_chosen_reg <= 4'(best_reg);
                    state_reg      <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_chosen_reg <= res_chosen_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Only a selected peer carries an index on the result channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_SELECTED) |-> (m_chosen == 4'd0))
        else $error("chosen index set on a result without a selection");

    // One transaction at a time: accepting one closes the request channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in progress");

    // The divider remainder stays below the divisor on every step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    // A selection can only reach the update step once a winner has been recorded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUPD) |-> found_reg)
        else $error("winner update without a usable peer");

endmodule

@@ tb/wrs_checker.sv @@
// Checker that predicts and compares the selector's results from the channel traffic.
module wrs_checker
    import wrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [3:0]  s_entry,
    input  logic [63:0] s_peer_hash,
    input  logic [15:0] s_weight,
    input  logic [63:0] s_key,
    input  logic [15:0] s_exclude_mask,
    input  logic [47:0] s_now,
    input  logic [1:0]  s_outcome,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [3:0]  m_chosen,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] chosen;
    } answer_t;

    wrs_entry_t table_m [WRS_PEERS];
    logic [7:0]  limit_m;
    logic [31:0] timeout_m;
    answer_t     answers_q[$];

    function automatic logic [63:0] splitmix(input logic [63:0] k, input logic [63:0] ph);
        logic [63:0] v;
        v = k ^ (ph + MIX_GOLDEN);
        v = v ^ (v >> 30);
        v = v * MIX_MUL1;
        v = v ^ (v >> 27);
        v = v * MIX_MUL2;
        v = v ^ (v >> 31);
        return v;
    endfunction

    function automatic logic [63:0] neglog_q26(input logic [63:0] h);
        logic [63:0] mid, mq, z, z2, p, t, s, e;
        int top;
        mid = ((h >> 11) << 1) | 64'd1;
        top = 0;
        for (int b = 0; b < 64; b++) if (mid[b]) top = b;
        e = 64'(53 - top);
        mq = (mid << (63 - top)) >> 32;
        z = ((64'h1_0000_0000 - mq) << 32) / (64'h1_0000_0000 + mq);
        z2 = (z * z) >> 32;
        p = 64'h1_0000_0000 / 64'd31;
        for (int k = 14; k >= 0; k--)
            p = 64'h1_0000_0000 / 64'(2 * k + 1) + ((z2 * p) >> 32);
        t = (z * p) >> 31;
        s = e * 64'hB17217F8 + t;
        return (s + 64'd32) >> 6;
    endfunction

    function automatic logic [47:0] since(input int i, input logic [47:0] tnow);
        return tnow >= table_m[i].last_checked ? tnow - table_m[i].last_checked : 48'd0;
    endfunction

    task automatic apply_request();
        answer_t a;
        logic found;
        int best;
        logic [63:0] best_l, best_w, l, w;
        a = '0;
        case (s_func)
            FUNC_LOAD: begin
                table_m[s_entry] = '{s_peer_hash, s_weight, 8'd0, 48'd0, 48'd0};
            end
            FUNC_SELECT: begin
                found = 1'b0;
                best = 0;
                best_l = 0;
                best_w = 1;
                for (int i = 0; i < WRS_PEERS; i++) begin
                    if (table_m[i].weight == 0 || s_exclude_mask[i]) continue;
                    if (!(limit_m == 0 || table_m[i].fail_count < limit_m ||
                          since(i, s_now) > {16'd0, timeout_m})) continue;
                    l = neglog_q26(splitmix(s_key, table_m[i].node_hash));
                    w = {48'd0, table_m[i].weight};
                    if (!found || l * best_w < best_l * w) begin
                        found = 1'b1;
                        best = i;
                        best_l = l;
                        best_w = w;
                    end
                end
                if (found) begin
                    if (since(best, s_now) > {16'd0, timeout_m})
                        table_m[best].last_checked = s_now;
                    a.status = STAT_SELECTED;
                    a.chosen = 4'(best);
                end else begin
                    a.status = STAT_NONE;
                end
            end
            FUNC_REPORT: begin
                if (table_m[s_entry].weight != 0) begin
                    if (s_outcome == OUTC_SUCCESS) begin
                        if (table_m[s_entry].last_failed < table_m[s_entry].last_checked)
                            table_m[s_entry].fail_count = 8'd0;
                    end else if (s_outcome == OUTC_FAILURE) begin
                        if (s_now > table_m[s_entry].last_checked)
                            table_m[s_entry].last_checked = s_now;
                        table_m[s_entry].last_failed = table_m[s_entry].last_checked;
                        if (table_m[s_entry].fail_count != 8'hFF)
                            table_m[s_entry].fail_count++;
                    end
                end
            end
            default: ;
        endcase
        answers_q = {answers_q, a};
    endtask

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            for (int i = 0; i < WRS_PEERS; i++) table_m[i] = '0;
            limit_m = FAIL_LIMIT_RST;
            timeout_m = RETRY_TIMEOUT_RST;
            answers_q.delete();
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FAIL_LIMIT) limit_m = cfg_data[7:0];
                else if (cfg_index == CFG_RETRY_TIMEOUT) timeout_m = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (answers_q.size() == 0) begin
                    $error("result with nothing expected: status %0d chosen %0d",
                           m_status, m_chosen);
                    errors++;
                end else begin
                    want = answers_q.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        errors++;
                    end
                    if (m_chosen !== want.chosen) begin
                        $error("chosen: expected %0d, actual %0d", want.chosen, m_chosen);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) apply_request();
        end
        pending = answers_q.size();
    end

endmodule

@@ tb/tb.sv @@
// Top-level testbench: stimulus, flow control and the verdict for the selector core.
module tb;
    import wrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [3:0]  s_entry = '0;
    logic [63:0] s_peer_hash = '0;
    logic [15:0] s_weight = '0;
    logic [63:0] s_key = '0;
    logic [15:0] s_exclude_mask = '0;
    logic [47:0] s_now = '0;
    logic [1:0]  s_outcome = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_chosen;

    int errors;
    int pending;
    longint unsigned cycles = 0;
    // Idling is switched off for the last part of the run.
    bit quiet_tail = 1'b0;
    // Requests a long receiver hold-off while requests keep coming.
    bit hold_request = 1'b0;
    // Monotonic time base; requests occasionally carry an earlier time on purpose.
    logic [47:0] clock_now = 48'd0;

    weighted_rendezvous_selector_core dut (.*);

    wrs_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The cycle counter is the run's watchdog, with a limit that leaves several times the
    // slowest correct run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd12_000_000) begin
            $display("weighted_rendezvous_selector_core test failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off when the sender asks for it.
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request && !held) begin
                m_ready <= 1'b0;
                repeat (6000) @(posedge aclk);
                held = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Sends one transaction on the request channel and waits until it is accepted. Valid
    // stays up into the next transaction; it drops only before an idle burst or when the
    // caller stops sending.
    task automatic send_request(input logic [1:0] f, input logic [3:0] ent,
                                input logic [63:0] ph, input logic [15:0] w,
                                input logic [63:0] k, input logic [15:0] msk,
                                input logic [47:0] tn, input logic [1:0] oc);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_entry <= ent;
        s_peer_hash <= ph;
        s_weight <= w;
        s_key <= k;
        s_exclude_mask <= msk;
        s_now <= tn;
        s_outcome <= oc;
        @(posedge aclk iff s_ready);
    endtask

    task automatic write_register(input logic [3:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk iff cfg_ready);
    endtask

    // Registers change only once every result is back and the block has settled.
    task automatic drain_block();
        s_valid <= 1'b0;
        @(posedge aclk iff pending == 0);
        repeat (30) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic advance_time();
        case ($urandom_range(0, 9))
            0: clock_now = clock_now + 48'($urandom_range(0, 40000));
            1: clock_now = clock_now + {16'd0, $urandom()};
            default: clock_now = clock_now + 48'($urandom_range(0, 300));
        endcase
    endtask

    // A random request, weighted toward selects and reports on a populated table.
    task automatic random_request();
        int pick;
        logic [47:0] tn;
        pick = $urandom_range(0, 99);
        advance_time();
        tn = ($urandom_range(0, 30) == 0) ? clock_now - 48'($urandom_range(1, 5000)) : clock_now;
        if (pick < 15) begin
            send_request(FUNC_LOAD, 4'($urandom()), rand64(), rand_weight(), rand64(),
                         16'($urandom()), tn, 2'($urandom()));
        end else if (pick < 55) begin
            // Excluding many entries keeps most selects short and makes empty results.
            send_request(FUNC_SELECT, 4'($urandom()), rand64(), 16'($urandom()), rand64(),
                         ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom()) |
                         16'($urandom()), tn, 2'($urandom()));
        end else if (pick < 97) begin
            send_request(FUNC_REPORT, 4'($urandom()), rand64(), 16'($urandom()), rand64(),
                         16'($urandom()), tn, ($urandom_range(0, 9) == 0) ? OUTC_SPARE :
                         2'($urandom_range(0, 2)));
        end else begin
            send_request(FUNC_SPARE, 4'($urandom()), rand64(), 16'($urandom()), rand64(),
                         16'($urandom()), tn, 2'($urandom()));
        end
    endtask

    initial begin
        logic [7:0]  limits [4];
        logic [31:0] timeouts [4];
        limits = '{8'd0, 8'd1, 8'd3, 8'd255};
        timeouts = '{32'd1, 32'd200, 32'd5000, 32'hFFFF_FFFF};
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: select on an empty table, loads at the field extremes, failure
        // reports that open circuits, success and neutral reports, func code three.
        send_request(FUNC_SELECT, 4'd0, '0, '0, '0, 16'h0000, 48'd0, OUTC_SUCCESS);
        send_request(FUNC_LOAD, 4'd0, 64'd0, 16'd1, '0, '0, 48'd0, OUTC_SUCCESS);
        send_request(FUNC_LOAD, 4'd15, '1, 16'hFFFF, '1, '1, '1, OUTC_SPARE);
        send_request(FUNC_LOAD, 4'd7, 64'h0123_4567_89AB_CDEF, 16'd300, '0, '0, 48'd5,
                     OUTC_SUCCESS);
        send_request(FUNC_SELECT, 4'd0, '0, '0, 64'd0, 16'h0000, 48'd10, OUTC_SUCCESS);
        send_request(FUNC_SELECT, 4'd0, '0, '0, '1, 16'h8000, '1, OUTC_SUCCESS);
        send_request(FUNC_SELECT, 4'd0, '0, '0, '1, 16'hFFFF, 48'd20, OUTC_SUCCESS);
        send_request(FUNC_REPORT, 4'd7, '0, '0, '0, '0, 48'd30, OUTC_FAILURE);
        send_request(FUNC_REPORT, 4'd0, '0, '0, '0, '0, 48'd40, OUTC_FAILURE);
        send_request(FUNC_REPORT, 4'd15, '0, '0, '0, '0, 48'd50, OUTC_FAILURE);
        send_request(FUNC_SELECT, 4'd0, '0, '0, 64'h55AA, 16'h0000, 48'd60, OUTC_SUCCESS);
        send_request(FUNC_REPORT, 4'd3, '0, '0, '0, '0, 48'd70, OUTC_FAILURE);
        send_request(FUNC_REPORT, 4'd7, '0, '0, '0, '0, 48'd20, OUTC_FAILURE);
        send_request(FUNC_REPORT, 4'd7, '0, '0, '0, '0, 48'd80, OUTC_SUCCESS);
        send_request(FUNC_REPORT, 4'd0, '0, '0, '0, '0, 48'd80, OUTC_NEUTRAL);
        send_request(FUNC_REPORT, 4'd0, '0, '0, '0, '0, 48'd80, OUTC_SPARE);
        send_request(FUNC_SELECT, 4'd0, '0, '0, 64'h1, 16'h0000, 48'd20000, OUTC_SUCCESS);
        send_request(FUNC_REPORT, 4'd15, '0, '0, '0, '0, 48'd20000, OUTC_SUCCESS);
        send_request(FUNC_SPARE, 4'd9, '1, '1, '1, '1, '1, OUTC_SPARE);
        clock_now = 48'd20000;

        // Random phases, each with its own breaker setting, the extremes among them.
        for (int ph = 0; ph < 8; ph++) begin
            drain_block();
            write_register(CFG_FAIL_LIMIT, {24'd0, (ph < 4) ? limits[ph] :
                           8'($urandom_range(0, 255))});
            write_register(CFG_RETRY_TIMEOUT, (ph < 4) ? timeouts[3 - ph] :
                           $urandom_range(1, 20000));
            cfg_valid <= 1'b0;
            if (ph == 2) hold_request = 1'b1;
            if (ph == 7) quiet_tail = 1'b1;
            for (int n = 0; n < 225; n++) random_request();
        end
        s_valid <= 1'b0;

        @(posedge aclk iff (pending == 0 && !s_valid));
        repeat (1500) @(posedge aclk);
        if (errors == 0) begin
            $display("weighted_rendezvous_selector_core test passed");
        end else begin
            $display("weighted_rendezvous_selector_core test failed");
        end
        $finish;
    end

endmodule
